FILE: rtl/sefp_pkg.sv
// Shared types and constants of the STX/ETX frame checker.
// No dependencies; every other file of the block but sefp_if imports this package.
package sefp_pkg;

    // Frame delimiters and signature bytes.
    localparam logic [7:0] STX_BYTE      = 8'h02;
    localparam logic [7:0] SIG_BYTE      = 8'hAA;
    localparam logic [7:0] SIG_SHORT     = 8'hAB;
    localparam logic [7:0] ETX_BYTE      = 8'h03;

    // Layout geometry.
    localparam logic [7:0] METADATA_BYTES = 8'd10;
    localparam logic [4:0] OFFSET_LONG   = 5'd16;
    localparam logic [4:0] OFFSET_SHORT  = 5'd6;
    localparam int unsigned CK_BASE_LONG  = 16;
    localparam int unsigned CK_BASE_SHORT = 6;
    localparam int unsigned MIN_LAST_POS  = 7;

    // Layout codes reported with a verdict.
    localparam logic [1:0] LAYOUT_SHORT      = 2'd0;
    localparam logic [1:0] LAYOUT_LEN_DATA   = 2'd1;
    localparam logic [1:0] LAYOUT_LEN_TOTAL  = 2'd2;

    // One received byte as held in the input register.
    typedef struct packed {
        logic [7:0] rx_byte;
        logic       is_last;
    } in_item_t;

    // One verdict.
    typedef struct packed {
        logic        frame_ok;
        logic [1:0]  layout;
        logic [15:0] frame_id;
        logic [4:0]  data_offset;
        logic [7:0]  data_length;
    } result_t;

endpackage

FILE: rtl/sefp_if.sv
// Valid/ready channel interfaces of the STX/ETX frame checker.
// Stand-alone; carries the byte stream in and the verdicts out.
interface sefp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       is_last;

    modport source (output valid, output rx_byte, output is_last, input ready);
    modport sink   (input valid, input rx_byte, input is_last, output ready);
endinterface

interface sefp_out_if;
    logic        valid;
    logic        ready;
    logic        frame_ok;
    logic [1:0]  layout;
    logic [15:0] frame_id;
    logic [4:0]  data_offset;
    logic [7:0]  data_length;

    modport source (output valid, output frame_ok, output layout, output frame_id,
                    output data_offset, output data_length, input ready);
    modport sink   (input valid, input frame_ok, input layout, input frame_id,
                    input data_offset, input data_length, output ready);
endinterface

FILE: rtl/stx_etx_frame_parser_top.sv
// Top level of the STX/ETX frame checker with XOR checksum.
// Depends on sefp_pkg, sefp_if, sefp_in_reg, sefp_core and sefp_out_reg.
//
// Usage: the received buffer streams in on rx, one byte per item, with
// is_last set on its final byte. Each buffer gives exactly one verdict on
// the verdict channel: frame_ok, the layout code, the 16-bit id, and the
// data offset and length (all zero when the frame fails).
//
// Timing: an accepted byte sits in the input register and is folded into
// the frame state as it moves on; for a last byte the verdict is loaded
// into the result register, raising verdict.valid, at that same edge. One
// byte per cycle is sustained while no last byte waits on a verdict, set by
// the single compare-and-XOR step between the input and state registers.
//
// Stall: while a verdict waits, bytes that do not end a buffer keep flowing;
// a last byte waits in the input register until the verdict is taken, and
// rx holds ready low meanwhile.
// Reset: rst_n clears both channel registers and the frame state. The
// position counter saturates at POSITION_LIMIT, which must stay at least
// 273 so every check position lies below it.
module stx_etx_frame_parser_top #(
    parameter int unsigned POSITION_LIMIT = 511
) (
    input  logic        clk,
    input  logic        rst_n,
    sefp_in_if.sink     rx,
    sefp_out_if.source  verdict
);
    import sefp_pkg::*;

    logic     item_valid;
    in_item_t item;
    logic     out_busy;
    logic     fire;
    result_t  result;

    // A byte moves on unless it ends a buffer and the verdict slot is full.
    assign fire = item_valid && !(item.is_last && out_busy);

    sefp_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx         (rx),
        .advance    (fire),
        .item_valid (item_valid),
        .item       (item)
    );

    sefp_core #(
        .POSITION_LIMIT (POSITION_LIMIT)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .item   (item),
        .result (result)
    );

    sefp_out_reg u_out_reg (
        .clk     (clk),
        .rst_n   (rst_n),
        .load    (fire && item.is_last),
        .result  (result),
        .busy    (out_busy),
        .verdict (verdict)
    );
endmodule

FILE: rtl/sefp_in_reg.sv
// Input register of the frame checker: takes bytes from the receive channel.
// Depends on sefp_pkg and sefp_in_if.
module sefp_in_reg (
    input  logic              clk,
    input  logic              rst_n,
    sefp_in_if.sink           rx,
    input  logic              advance,
    output logic              item_valid,
    output sefp_pkg::in_item_t item
);
    import sefp_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;
    logic     take;

    // The register frees up in the same cycle its item moves on.
    assign rx.ready   = !valid_reg || advance;
    assign take       = rx.valid && rx.ready;
    assign valid_next = take ? 1'b1 : (advance ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg.rx_byte <= rx.rx_byte;
            item_reg.is_last <= rx.is_last;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;
endmodule

FILE: rtl/sefp_core.sv
// Frame state and verdict logic: position counter, running XOR, header
// fields and checksum/ETX flags for both length readings. Depends on sefp_pkg.
module sefp_core #(
    parameter int unsigned POSITION_LIMIT = 511
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               fire,
    input  sefp_pkg::in_item_t item,
    output sefp_pkg::result_t  result
);
    import sefp_pkg::*;

    localparam int unsigned PosW = $clog2(POSITION_LIMIT + 1);
    localparam logic [PosW-1:0] PosMax = PosW'(POSITION_LIMIT);

    logic [PosW-1:0] pos_reg, pos_next;
    logic [7:0]      xor_reg, xor_next;
    logic            long_reg, long_next;
    logic [7:0]      len_reg, len_next;
    logic [15:0]     id_reg, id_next;
    logic            hdr_reg, hdr_next;
    logic            cka_reg, cka_next;
    logic            enda_reg, enda_next;
    logic            ckb_reg, ckb_next;
    logic            endb_reg, endb_next;

    logic [7:0]      b;
    logic [PosW-1:0] ck_a;
    logic [PosW-1:0] ck_b;

    assign b    = item.rx_byte;
    assign ck_a = PosW'(CK_BASE_LONG) + PosW'(len_reg);
    assign ck_b = PosW'(CK_BASE_SHORT) + PosW'(len_reg);

    // Per-byte update of the frame state.
    always_comb
    begin
        hdr_next  = hdr_reg;
        long_next = long_reg;
        len_next  = len_reg;
        id_next   = id_reg;
        cka_next  = cka_reg;
        enda_next = enda_reg;
        ckb_next  = ckb_reg;
        endb_next = endb_reg;

        if (pos_reg == PosW'(0))
        begin
            if (b != STX_BYTE) hdr_next = 1'b0;
        end
        else if (pos_reg == PosW'(1))
        begin
            if (b != SIG_BYTE) hdr_next = 1'b0;
        end
        else if (pos_reg == PosW'(2))
        begin
            if (b == SIG_BYTE) long_next = 1'b1;
            else if (b != SIG_SHORT) hdr_next = 1'b0;
        end
        else if (pos_reg == PosW'(3))
        begin
            len_next = b;
        end
        else if (pos_reg == PosW'(4))
        begin
            id_next = {id_reg[15:8], b};
        end
        else if (pos_reg == PosW'(5))
        begin
            id_next = {b, id_reg[7:0]};
        end
        else
        begin
            if (pos_reg == ck_a && b == xor_reg) cka_next = 1'b1;
            if (pos_reg == ck_a + PosW'(1) && b == ETX_BYTE) enda_next = 1'b1;
            if (pos_reg == ck_b && b == xor_reg) ckb_next = 1'b1;
            if (pos_reg == ck_b + PosW'(1) && b == ETX_BYTE) endb_next = 1'b1;
        end

        // The STX byte is not part of the checksum.
        xor_next = (pos_reg != PosW'(0)) ? (xor_reg ^ b) : xor_reg;
        pos_next = (pos_reg < PosMax) ? (pos_reg + PosW'(1)) : pos_reg;
    end

    // Verdict, taken from the state as it stands after this byte.
    always_comb
    begin
        result = '0;
        if (pos_reg >= PosW'(MIN_LAST_POS) && hdr_next)
        begin
            if (!long_next)
            begin
                if (ckb_next && endb_next)
                begin
                    result.frame_ok    = 1'b1;
                    result.layout      = LAYOUT_SHORT;
                    result.data_offset = OFFSET_SHORT;
                    result.data_length = len_next;
                end
            end
            else if (cka_next && enda_next)
            begin
                result.frame_ok    = 1'b1;
                result.layout      = LAYOUT_LEN_DATA;
                result.data_offset = OFFSET_LONG;
                result.data_length = len_next;
            end
            else if (ckb_next && endb_next && len_next >= METADATA_BYTES)
            begin
                result.frame_ok    = 1'b1;
                result.layout      = LAYOUT_LEN_TOTAL;
                result.data_offset = OFFSET_LONG;
                result.data_length = len_next - METADATA_BYTES;
            end
            if (result.frame_ok) result.frame_id = id_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            xor_reg  <= '0;
            long_reg <= 1'b0;
            len_reg  <= '0;
            id_reg   <= '0;
            hdr_reg  <= 1'b1;
            cka_reg  <= 1'b0;
            enda_reg <= 1'b0;
            ckb_reg  <= 1'b0;
            endb_reg <= 1'b0;
        end
        else if (fire)
        begin
            if (item.is_last)
            begin
                // A verdict ends the buffer; the next byte starts a new one.
                pos_reg  <= '0;
                xor_reg  <= '0;
                long_reg <= 1'b0;
                len_reg  <= '0;
                id_reg   <= '0;
                hdr_reg  <= 1'b1;
                cka_reg  <= 1'b0;
                enda_reg <= 1'b0;
                ckb_reg  <= 1'b0;
                endb_reg <= 1'b0;
            end
            else
            begin
                pos_reg  <= pos_next;
                xor_reg  <= xor_next;
                long_reg <= long_next;
                len_reg  <= len_next;
                id_reg   <= id_next;
                hdr_reg  <= hdr_next;
                cka_reg  <= cka_next;
                enda_reg <= enda_next;
                ckb_reg  <= ckb_next;
                endb_reg <= endb_next;
            end
        end
    end
endmodule

FILE: rtl/sefp_out_reg.sv
// Result register of the frame checker: holds one verdict until taken.
// Depends on sefp_pkg and sefp_out_if.
module sefp_out_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  sefp_pkg::result_t result,
    output logic              busy,
    sefp_out_if.source        verdict
);
    import sefp_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t data_reg;

    // Busy means a held verdict will not leave this cycle.
    assign busy       = valid_reg && !verdict.ready;
    assign valid_next = load ? 1'b1 : (verdict.ready ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= result;
        end
    end

    assign verdict.valid       = valid_reg;
    assign verdict.frame_ok    = data_reg.frame_ok;
    assign verdict.layout      = data_reg.layout;
    assign verdict.frame_id    = data_reg.frame_id;
    assign verdict.data_offset = data_reg.data_offset;
    assign verdict.data_length = data_reg.data_length;
endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the STX/ETX frame checker with XOR checksum.
// Depends on sefp_pkg, the sefp_in_if / sefp_out_if channel interfaces and
// the stx_etx_frame_parser_top RTL.
module testbench;

    import sefp_pkg::*;

    // The position counter limit given to the block and mirrored by the
    // predictor below. The lowest legal value puts the checks of the longest
    // frame right below the saturation point.
    localparam int unsigned POS_LIMIT = 273;

    // Cycles without any handshake on either channel before the run is
    // declared hung. The longest legal quiet stretch comes from the deliberate
    // receiver hold-off, so this leaves a wide margin.
    localparam int unsigned QUIET_LIMIT = 2000;

    // Cycles to keep watching after the last verdict, well past the input and
    // result registers between an accepted last byte and its verdict.
    localparam int unsigned TAIL_CYCLES = 8;

    // The first few mismatches are printed in full; later ones are counted.
    localparam int unsigned MAX_REPORTS = 10;

    // Frame shapes the stimulus builder can lay out.
    typedef enum {
        SHAPE_SHORT,      // AB signature, length counts data only
        SHAPE_LEN_DATA,   // AA signature, 10 metadata bytes plus length data
        SHAPE_LEN_TOTAL   // AA signature, length counts metadata plus data
    } shape_t;

    // Ways a well-formed frame gets damaged in the random traffic.
    typedef enum {
        DAMAGE_FLIP,      // one bit of one byte inverted
        DAMAGE_TRUNCATE,  // buffer cut short
        DAMAGE_HEADER     // one of the first four bytes overwritten
    } damage_t;

    logic clk = 1'b0;
    logic rst_n;

    sefp_in_if  rx_ch();
    sefp_out_if verdict_ch();

    stx_etx_frame_parser_top #(
        .POSITION_LIMIT(POS_LIMIT)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .rx(rx_ch),
        .verdict(verdict_ch)
    );

    // A 4 ns clock period.
    always #2 clk = ~clk;

    // ------------------------------------------------------------------
    // Frame state of the predictor. It tracks the block's view of the
    // buffer under way: where we are in it, the running XOR, the header
    // fields, and which of the two checksum/ETX readings has been seen.
    // ------------------------------------------------------------------
    int unsigned pos_cnt;
    logic [7:0]  xor_acc;
    logic        is_long;
    logic [7:0]  len_byte;
    logic [15:0] id_word;
    logic        hdr_ok;
    logic        ck_long_ok;
    logic        etx_long_ok;
    logic        ck_short_ok;
    logic        etx_short_ok;

    // Verdicts predicted but not yet seen on the verdict channel, oldest first.
    result_t verdicts_due[$];

    // The buffer about to be streamed in, built by the stimulus tasks.
    logic [7:0] frame_buf[$];

    // Idle percentages of the current phase: how often the sender leaves a
    // gap before an item, and how often the receiver drops ready.
    int src_idle_pct   = 0;
    int sink_stall_pct = 0;

    // A test asks for a receiver hold-off by setting hold_len and bumping
    // hold_seq; the ready process notices the new request and counts the
    // hold-off down on its own.
    int hold_len  = 0;
    int hold_seq  = 0;
    int hold_seen = 0;
    int hold_left = 0;

    int unsigned bytes_sent = 0;
    int unsigned fail_count = 0;
    int unsigned quiet_cycles = 0;

    // Every buffer starts from the same state: nothing seen, header assumed
    // good until a wrong STX or signature byte shows up.
    function automatic void clear_frame_state();
        pos_cnt      = 0;
        xor_acc      = '0;
        is_long      = 1'b0;
        len_byte     = '0;
        id_word      = '0;
        hdr_ok       = 1'b1;
        ck_long_ok   = 1'b0;
        etx_long_ok  = 1'b0;
        ck_short_ok  = 1'b0;
        etx_short_ok = 1'b0;
    endfunction

    // Folds one accepted byte into the frame state. On the last byte of a
    // buffer it hands back the verdict and starts over for the next buffer.
    function automatic void predict_byte(input logic [7:0] b, input logic last,
                                         output logic has_verdict,
                                         output result_t verdict);
        int unsigned p;
        int unsigned ck_pos_long;
        int unsigned ck_pos_short;
        p = pos_cnt;
        verdict = '0;
        has_verdict = 1'b0;

        if (p == 0)
        begin
            if (b != STX_BYTE) hdr_ok = 1'b0;
        end
        else if (p == 1)
        begin
            if (b != SIG_BYTE) hdr_ok = 1'b0;
        end
        else if (p == 2)
        begin
            if (b == SIG_BYTE) is_long = 1'b1;
            else if (b != SIG_SHORT) hdr_ok = 1'b0;
        end
        else if (p == 3)
        begin
            len_byte = b;
        end
        else if (p == 4)
        begin
            id_word[7:0] = b;
        end
        else if (p == 5)
        begin
            id_word[15:8] = b;
        end
        else
        begin
            // Both readings are tracked side by side on every frame; the
            // signature only decides at the end which ones may count.
            ck_pos_long  = CK_BASE_LONG + len_byte;
            ck_pos_short = CK_BASE_SHORT + len_byte;
            if (p == ck_pos_long && b == xor_acc) ck_long_ok = 1'b1;
            if (p == ck_pos_long + 1 && b == ETX_BYTE) etx_long_ok = 1'b1;
            if (p == ck_pos_short && b == xor_acc) ck_short_ok = 1'b1;
            if (p == ck_pos_short + 1 && b == ETX_BYTE) etx_short_ok = 1'b1;
        end

        // The checksum covers everything after the STX, so the checksum byte
        // itself is folded in too; it is compared before that happens.
        if (p >= 1) xor_acc = xor_acc ^ b;
        if (p < POS_LIMIT) pos_cnt = p + 1;

        if (last)
        begin
            has_verdict = 1'b1;
            if (p >= MIN_LAST_POS && hdr_ok)
            begin
                if (!is_long)
                begin
                    if (ck_short_ok && etx_short_ok)
                    begin
                        verdict.frame_ok    = 1'b1;
                        verdict.layout      = LAYOUT_SHORT;
                        verdict.data_offset = OFFSET_SHORT;
                        verdict.data_length = len_byte;
                    end
                end
                else if (ck_long_ok && etx_long_ok)
                begin
                    verdict.frame_ok    = 1'b1;
                    verdict.layout      = LAYOUT_LEN_DATA;
                    verdict.data_offset = OFFSET_LONG;
                    verdict.data_length = len_byte;
                end
                else if (ck_short_ok && etx_short_ok && len_byte >= METADATA_BYTES)
                begin
                    verdict.frame_ok    = 1'b1;
                    verdict.layout      = LAYOUT_LEN_TOTAL;
                    verdict.data_offset = OFFSET_LONG;
                    verdict.data_length = len_byte - METADATA_BYTES;
                end
                if (verdict.frame_ok) verdict.frame_id = id_word;
            end
            clear_frame_state();
        end
    endfunction

    // Records one failure; only the first few are printed.
    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS) $display("%s", msg);
    endtask

    // ------------------------------------------------------------------
    // Stimulus side.
    // ------------------------------------------------------------------

    // Offers one item and returns at the edge where it is accepted. Valid is
    // left high on return, so back-to-back items keep it asserted; it is only
    // lowered in a gap or once the stimulus is over.
    task automatic send_byte(input logic [7:0] value, input logic last);
        logic    has_verdict;
        result_t verdict;
        while ($urandom_range(99) < src_idle_pct)
        begin
            rx_ch.valid <= 1'b0;
            @(posedge clk);
        end
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= value;
        rx_ch.is_last <= last;
        @(posedge clk);
        while (!rx_ch.ready) @(posedge clk);
        predict_byte(value, last, has_verdict, verdict);
        if (has_verdict) verdicts_due.push_back(verdict);
        bytes_sent++;
    endtask

    // Streams the whole of frame_buf as one buffer.
    task automatic send_buffer();
        for (int i = 0; i < frame_buf.size(); i++)
            send_byte(frame_buf[i], i == frame_buf.size() - 1);
    endtask

    // Appends the XOR of bytes 1 onward, then the ETX.
    task automatic append_checksum_etx();
        logic [7:0] sum;
        sum = '0;
        for (int i = 1; i < frame_buf.size(); i++) sum ^= frame_buf[i];
        frame_buf.push_back(sum);
        frame_buf.push_back(ETX_BYTE);
    endtask

    // Lays out a correct frame of the given shape with random body bytes,
    // followed by pad random bytes after the ETX.
    task automatic build_frame(input shape_t shape, input logic [7:0] len,
                               input logic [15:0] id, input int pad);
        int body;
        frame_buf.delete();
        frame_buf.push_back(STX_BYTE);
        frame_buf.push_back(SIG_BYTE);
        frame_buf.push_back(shape == SHAPE_SHORT ? SIG_SHORT : SIG_BYTE);
        frame_buf.push_back(len);
        frame_buf.push_back(id[7:0]);
        frame_buf.push_back(id[15:8]);
        body = (shape == SHAPE_LEN_DATA) ? int'(METADATA_BYTES) + int'(len) : int'(len);
        repeat (body) frame_buf.push_back(8'($urandom_range(255)));
        append_checksum_etx();
        repeat (pad) frame_buf.push_back(8'($urandom_range(255)));
    endtask

    // Fills frame_buf with n random bytes.
    task automatic fill_noise(input int n);
        frame_buf.delete();
        repeat (n) frame_buf.push_back(8'($urandom_range(255)));
    endtask

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------

    // Good frames in each layout.
    task automatic test_valid_layouts();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        build_frame(SHAPE_SHORT, 8'd0, 16'h0000, 0);
        send_buffer();
        build_frame(SHAPE_LEN_DATA, 8'd0, 16'h00FF, 0);
        send_buffer();
        build_frame(SHAPE_LEN_TOTAL, METADATA_BYTES, 16'h1234, 0);
        send_buffer();
        // Trailing bytes after the ETX are ignored.
        build_frame(SHAPE_SHORT, 8'd3, 16'h5AA5, 5);
        send_buffer();
        // An AA frame where both readings hold: the total-length reading
        // ends at 7+L, then eight more bytes bring the data-length reading's
        // checksum and ETX. The data-length reading must win.
        build_frame(SHAPE_LEN_TOTAL, 8'd12, 16'hBEEF, 0);
        repeat (8) frame_buf.push_back(8'($urandom_range(255)));
        append_checksum_etx();
        send_buffer();
    endtask

    // Buffers that must be rejected, one for each way a frame can fail.
    task automatic test_rejected_buffers();
        src_idle_pct   = 21;
        sink_stall_pct = 21;
        // One-byte buffer.
        frame_buf.delete();
        frame_buf.push_back(STX_BYTE);
        send_buffer();
        // Seven bytes: one short of the smallest legal frame.
        build_frame(SHAPE_SHORT, 8'd0, 16'h0102, 0);
        void'(frame_buf.pop_back());
        send_buffer();
        // Wrong STX.
        build_frame(SHAPE_SHORT, 8'd3, 16'h0304, 0);
        frame_buf[0] = 8'hFF;
        send_buffer();
        // Wrong first signature byte.
        build_frame(SHAPE_SHORT, 8'd3, 16'h0506, 0);
        frame_buf[1] = SIG_SHORT;
        send_buffer();
        // Wrong second signature byte.
        build_frame(SHAPE_SHORT, 8'd3, 16'h0708, 0);
        frame_buf[2] = 8'hAC;
        send_buffer();
        // Bad checksum.
        build_frame(SHAPE_SHORT, 8'd4, 16'h090A, 0);
        frame_buf[CK_BASE_SHORT + 4] ^= 8'h01;
        send_buffer();
        // Buffer ends before the ETX.
        build_frame(SHAPE_SHORT, 8'd4, 16'h0B0C, 0);
        void'(frame_buf.pop_back());
        send_buffer();
        // Buffer ends before both checksum and ETX.
        build_frame(SHAPE_LEN_DATA, 8'd2, 16'h0D0E, 0);
        void'(frame_buf.pop_back());
        void'(frame_buf.pop_back());
        send_buffer();
        // Total-length reading with a length below the metadata size.
        build_frame(SHAPE_LEN_TOTAL, 8'd5, 16'h0F10, 0);
        send_buffer();
        // Wrong ETX on a data-length frame.
        build_frame(SHAPE_LEN_DATA, 8'd1, 16'h1112, 0);
        frame_buf[frame_buf.size() - 1] = 8'h04;
        send_buffer();
    endtask

    // The longest data-length frame puts its ETX one below the position
    // limit; the trailing bytes then run the counter into saturation, and
    // the verdict only depends on what came before.
    task automatic test_saturated_position();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        build_frame(SHAPE_LEN_DATA, 8'd255, 16'hC0DE, 12);
        send_buffer();
    endtask

    // The receiver holds off for a long stretch while the sender keeps
    // offering short frames, so a verdict waits in the block and the next
    // last byte stalls the input.
    task automatic test_backpressure();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        hold_len = 300;
        hold_seq++;
        repeat (6)
        begin
            build_frame(SHAPE_SHORT, 8'd2, 16'($urandom_range(65535)), 0);
            send_buffer();
        end
    endtask

    // Mostly well-formed frames with random content, some of them damaged,
    // and some plain noise.
    task automatic test_random_traffic(input int src_pct, input int sink_pct,
                                       input int n_bytes);
        int unsigned start;
        int          pick;
        int          len;
        int          idx;
        shape_t      shape;
        damage_t     damage;
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        start = bytes_sent;
        while (bytes_sent - start < n_bytes)
        begin
            pick = $urandom_range(99);
            if (pick < 8)
            begin
                fill_noise($urandom_range(1, 40));
                if ($urandom_range(1) == 1) frame_buf[0] = STX_BYTE;
            end
            else
            begin
                shape = shape_t'($urandom_range(2));
                if ($urandom_range(14) == 0) len = $urandom_range(255);
                else len = $urandom_range(16);
                if (shape == SHAPE_LEN_TOTAL && len < METADATA_BYTES)
                    len += METADATA_BYTES;
                build_frame(shape, 8'(len), 16'($urandom_range(65535)),
                            ($urandom_range(3) == 0) ? $urandom_range(1, 4) : 0);
                if (pick < 28)
                begin
                    damage = damage_t'($urandom_range(2));
                    case (damage)
                        DAMAGE_FLIP:
                        begin
                            idx = $urandom_range(frame_buf.size() - 1);
                            frame_buf[idx] ^= 8'(1 << $urandom_range(7));
                        end
                        DAMAGE_TRUNCATE:
                        begin
                            idx = $urandom_range(1, frame_buf.size() - 1);
                            while (frame_buf.size() > idx) void'(frame_buf.pop_back());
                        end
                        default:
                        begin
                            frame_buf[$urandom_range(3)] = 8'($urandom_range(255));
                        end
                    endcase
                end
            end
            send_buffer();
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver side: ready with random stalls and the optional long
    // hold-off, driven at the rising edge.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (hold_seq != hold_seen)
        begin
            hold_seen = hold_seq;
            hold_left = hold_len;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            verdict_ch.ready <= 1'b0;
        end
        else
        begin
            verdict_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // Each accepted verdict is compared field by field with the oldest
    // prediction. Values are read right after the edge, so they are the
    // ones the edge saw.
    always @(posedge clk)
    begin : verdict_check
        result_t seen;
        result_t want;
        if (rst_n && verdict_ch.valid && verdict_ch.ready)
        begin
            seen.frame_ok    = verdict_ch.frame_ok;
            seen.layout      = verdict_ch.layout;
            seen.frame_id    = verdict_ch.frame_id;
            seen.data_offset = verdict_ch.data_offset;
            seen.data_length = verdict_ch.data_length;
            if (verdicts_due.size() == 0)
            begin
                note_failure($sformatf(
                    "unexpected verdict: ok=%0d layout=%0d id=%h off=%0d len=%0d",
                    seen.frame_ok, seen.layout, seen.frame_id,
                    seen.data_offset, seen.data_length));
            end
            else
            begin
                want = verdicts_due.pop_front();
                if (seen.frame_ok !== want.frame_ok || seen.layout !== want.layout ||
                    seen.frame_id !== want.frame_id ||
                    seen.data_offset !== want.data_offset ||
                    seen.data_length !== want.data_length)
                begin
                    note_failure($sformatf({"verdict mismatch: expected ok=%0d layout=%0d ",
                                 "id=%h off=%0d len=%0d, got ok=%0d layout=%0d id=%h ",
                                 "off=%0d len=%0d"},
                                 want.frame_ok, want.layout, want.frame_id,
                                 want.data_offset, want.data_length,
                                 seen.frame_ok, seen.layout, seen.frame_id,
                                 seen.data_offset, seen.data_length));
                end
            end
        end
    end

    // Watchdog: a long run of cycles with no handshake on either channel
    // means the block or the testbench is stuck.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((rx_ch.valid && rx_ch.ready) || (verdict_ch.valid && verdict_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("watchdog: no handshake for %0d cycles", QUIET_LIMIT);
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Test sequence. Reset is held low at the start, then the directed
    // tests run, then random traffic in four idling phases. At the end the
    // sender goes quiet, the remaining verdicts drain, and a closing watch
    // catches any stray verdict before the final message.
    // ------------------------------------------------------------------
    initial
    begin
        rst_n         <= 1'b0;
        rx_ch.valid   <= 1'b0;
        rx_ch.rx_byte <= '0;
        rx_ch.is_last <= 1'b0;
        clear_frame_state();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_valid_layouts();
        test_rejected_buffers();
        test_saturated_position();
        test_backpressure();
        test_random_traffic(0, 0, 45);
        test_random_traffic(56, 0, 45);
        test_random_traffic(0, 56, 45);
        test_random_traffic(21, 21, 45);

        rx_ch.valid <= 1'b0;
        while (verdicts_due.size() != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

FILE: stx_etx_frame_parser_top.f
rtl/sefp_pkg.sv
rtl/sefp_if.sv
rtl/sefp_in_reg.sv
rtl/sefp_core.sv
rtl/sefp_out_reg.sv
rtl/stx_etx_frame_parser_top.sv
tb/sv/testbench.sv
